// ===== rtl/rcbp_pkg.sv =====
// Package for the Rice code bit packer: beat types, command/status structs,
// controller state type and packing constants. No dependencies.
`default_nettype none
package rcbp_pkg;

   localparam int unsigned WORD_BITS    = 64;
   localparam int unsigned MAX_K        = 15;
   localparam int unsigned MAX_QUOTIENT = 3900;
   localparam int unsigned K_BITS       = 4;
   localparam int unsigned VALUE_BITS   = 27;
   localparam int unsigned ZERO_BITS    = 12;   // holds quotients up to MAX_QUOTIENT
   localparam int unsigned FREE_BITS    = 7;    // free count 1..64
   localparam int unsigned LEN_BITS     = 5;    // code tail length 1..16
   localparam int unsigned TAIL_BITS    = 16;

   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   typedef struct packed {
      logic                  operation;
      logic [K_BITS-1:0]     low_bit_count;
      logic [VALUE_BITS-1:0] code_value;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] packed_word;
      logic                 rejected;
      logic                 last_word;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_BUSY
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture a new item
      logic step;      // advance the pending item by one step
      logic out_load;  // write the result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic emit;      // the next step gives a word
      logic done;      // the next step finishes the item
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/rcbp_ctrl.sv =====
// Controller for the Rice code bit packer: item state machine, result valid
// and handshakes. Uses rcbp_pkg.
`default_nettype none
module rcbp_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   input  rcbp_pkg::status_type status,
   output rcbp_pkg::cmd_type    cmd
);

   rcbp_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rcbp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      fire      = 1'b0;
      req_ready = 1'b0;
      state_in  = state_ff;
      case (state_ff)
         rcbp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         rcbp_pkg::ST_BUSY: begin
            // a step that gives a word waits for room in the result register
            fire      = !status.emit || out_free;
            req_ready = fire && status.done;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase

      cmd.load     = req_valid && req_ready;
      cmd.step     = fire;
      cmd.out_load = fire && status.emit;

      if (cmd.load) begin
         state_in = rcbp_pkg::ST_BUSY;
      end else if (fire && status.done) begin
         state_in = rcbp_pkg::ST_IDLE;
      end

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== rtl/rcbp_datapath.sv =====
// Datapath for the Rice code bit packer: item registers, 64-bit accumulator,
// free count and result register. Uses rcbp_pkg; driven by rcbp_ctrl.
`default_nettype none
module rcbp_datapath (
   input  wire                  clock,
   input  wire                  reset,
   input  rcbp_pkg::req_type    req_data,
   input  rcbp_pkg::cmd_type    cmd,
   output rcbp_pkg::status_type status,
   output rcbp_pkg::rsp_type    rsp_data
);

   localparam logic [rcbp_pkg::FREE_BITS-1:0] FULL_FREE =
      rcbp_pkg::FREE_BITS'(rcbp_pkg::WORD_BITS);

   // pending item
   logic                              op_ff, op_in;
   logic                              rej_ff, rej_in;
   logic [rcbp_pkg::ZERO_BITS-1:0]    zero_ff, zero_in;
   logic [rcbp_pkg::LEN_BITS-1:0]     len_ff, len_in;
   logic [rcbp_pkg::TAIL_BITS-1:0]    tail_ff, tail_in;
   // packing state
   logic [rcbp_pkg::WORD_BITS-1:0]    acc_ff, acc_in;
   logic [rcbp_pkg::FREE_BITS-1:0]    free_ff, free_in;
   rcbp_pkg::rsp_type                 rsp_ff, rsp_in;

   logic [rcbp_pkg::VALUE_BITS-1:0]   quot;
   logic [rcbp_pkg::TAIL_BITS-1:0]    low_mask;
   logic                              run_word;
   logic [rcbp_pkg::ZERO_BITS:0]      zero_left;
   logic [rcbp_pkg::ZERO_BITS:0]      run_end;
   logic [rcbp_pkg::FREE_BITS-1:0]    free_after_run;
   logic                              tail_fills;
   logic [rcbp_pkg::LEN_BITS-1:0]     spill;
   logic [rcbp_pkg::FREE_BITS-1:0]    tail_shift;
   logic [rcbp_pkg::WORD_BITS-1:0]    tail_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         free_ff <= FULL_FREE;
      end else begin
         acc_ff  <= acc_in;
         free_ff <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      rej_ff  <= rej_in;
      zero_ff <= zero_in;
      len_ff  <= len_in;
      tail_ff <= tail_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      // item capture
      quot     = req_data.code_value >> req_data.low_bit_count;
      low_mask = ~({rcbp_pkg::TAIL_BITS{1'b1}} << req_data.low_bit_count);

      // zero run against the free bits
      run_word       = {{(rcbp_pkg::ZERO_BITS-rcbp_pkg::FREE_BITS){1'b0}}, free_ff}
                       <= zero_ff;
      zero_left      = {1'b0, zero_ff}
                       - {{(rcbp_pkg::ZERO_BITS+1-rcbp_pkg::FREE_BITS){1'b0}}, free_ff};
      // after a run word, no further word if the rest plus the tail fits
      run_end        = {1'b0, zero_left[rcbp_pkg::ZERO_BITS-1:0]}
                       + {{(rcbp_pkg::ZERO_BITS+1-rcbp_pkg::LEN_BITS){1'b0}}, len_ff};
      free_after_run = free_ff - zero_ff[rcbp_pkg::FREE_BITS-1:0];

      // stop bit and low bits
      tail_fills = {{(rcbp_pkg::FREE_BITS-rcbp_pkg::LEN_BITS){1'b0}}, len_ff}
                   >= free_after_run;
      spill      = len_ff - free_after_run[rcbp_pkg::LEN_BITS-1:0];
      tail_shift = free_after_run - {{(rcbp_pkg::FREE_BITS-rcbp_pkg::LEN_BITS){1'b0}}, len_ff};
      tail_wide  = {{(rcbp_pkg::WORD_BITS-rcbp_pkg::TAIL_BITS){1'b0}}, tail_ff};

      if (op_ff == rcbp_pkg::OP_FLUSH || rej_ff) begin
         status.emit = 1'b1;
         status.done = 1'b1;
      end else if (run_word) begin
         status.emit = 1'b1;
         status.done = 1'b0;
      end else begin
         status.emit = tail_fills;
         status.done = 1'b1;
      end

      op_in   = op_ff;
      rej_in  = rej_ff;
      zero_in = zero_ff;
      len_in  = len_ff;
      tail_in = tail_ff;
      acc_in  = acc_ff;
      free_in = free_ff;
      rsp_in  = rsp_ff;

      if (cmd.step) begin
         if (op_ff == rcbp_pkg::OP_FLUSH) begin
            rsp_in.packed_word = acc_ff;
            rsp_in.rejected    = 1'b0;
            rsp_in.last_word   = 1'b1;
         end else if (rej_ff) begin
            rsp_in.packed_word = '0;
            rsp_in.rejected    = 1'b1;
            rsp_in.last_word   = 1'b1;
         end else if (run_word) begin
            rsp_in.packed_word = acc_ff;
            rsp_in.rejected    = 1'b0;
            rsp_in.last_word   = run_end < (rcbp_pkg::ZERO_BITS+1)'(rcbp_pkg::WORD_BITS);
            zero_in            = zero_left[rcbp_pkg::ZERO_BITS-1:0];
            acc_in             = '0;
            free_in            = FULL_FREE;
         end else if (tail_fills) begin
            rsp_in.packed_word = acc_ff | (tail_wide >> spill);
            rsp_in.rejected    = 1'b0;
            rsp_in.last_word   = 1'b1;
            // spilled low bits go to the top of a fresh word; none spilled gives 0
            acc_in  = tail_wide << (FULL_FREE - {2'b00, spill});
            free_in = FULL_FREE - {2'b00, spill};
         end else begin
            acc_in  = acc_ff | (tail_wide << tail_shift);
            free_in = tail_shift;
         end
      end

      // the next item may be captured in the cycle the current one finishes
      if (cmd.load) begin
         op_in   = req_data.operation;
         rej_in  = quot > rcbp_pkg::VALUE_BITS'(rcbp_pkg::MAX_QUOTIENT);
         zero_in = quot[rcbp_pkg::ZERO_BITS-1:0];
         len_in  = {1'b0, req_data.low_bit_count} + rcbp_pkg::LEN_BITS'(1);
         tail_in = (req_data.code_value[rcbp_pkg::TAIL_BITS-1:0] & low_mask)
                   | (rcbp_pkg::TAIL_BITS'(1) << req_data.low_bit_count);
      end

      if (!cmd.out_load) begin
         rsp_in = rsp_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

// ===== rtl/rice_code_bit_packer.sv =====
// Rice code bit packer top level: joins the controller and the datapath.
// Uses rcbp_pkg, rcbp_ctrl and rcbp_datapath.
//
// Usage:
//   req_ channel: one beat per item, operation encode (zero run of
//   code_value >> low_bit_count, stop bit, low bits) or flush.
//   rsp_ channel: finished 64-bit words, first code bit in bit 63. The final
//   result beat of an item has last_word set; an encode that fills no word
//   gives no beat. A quotient above the limit gives one beat with rejected
//   set and a zero word, and the packing state stays as it was.
//   Flush gives the accumulator as it stands and keeps it.
// Timing:
//   An item is captured at accept and stepped while the controller is busy.
//   One step places the stop and low bits (or handles a flush or reject),
//   after one step per word a zero run fills, so short codes go at one item
//   per cycle when no step waits for room in the result register. The next
//   item is accepted in the cycle the current one finishes.
// Reset clears the accumulator, sets 64 free bits and drops rsp_valid.
// When the receiver stalls, the result register holds its beat; a step that
// has a further word to give waits, and req_ready stays low meanwhile.
`default_nettype none
module rice_code_bit_packer (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  rcbp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output rcbp_pkg::rsp_type rsp_data
);

   rcbp_pkg::cmd_type    cmd;
   rcbp_pkg::status_type status;

   rcbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rcbp_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

// ===== verif/rice_code_bit_packer_tb.sv =====
// Self-checking testbench for rice_code_bit_packer: directed table, then random codes.
// It predicts the packed words and compares them beat by beat on the rsp_ channel.
// Depends on rcbp_pkg and the rice_code_bit_packer RTL.
`timescale 1ns / 1ps
module rice_code_bit_packer_tb;

   localparam int DIRECTED_COUNT = 20;
   localparam int RANDOM_ITEMS   = 480;
   localparam int DRAIN_CYCLES   = 16;

   typedef struct packed {
      rcbp_pkg::req_type item;
      logic              typed;    // golden beat typed in below, else taken from the predictor
      rcbp_pkg::rsp_type golden;
   } code_row_type;

   localparam rcbp_pkg::rsp_type REJECT_BEAT =
      '{packed_word: 64'd0, rejected: 1'b1, last_word: 1'b1};
   localparam rcbp_pkg::rsp_type NO_BEAT     = '0;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   rcbp_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rcbp_pkg::rsp_type rsp_data;

   // predictor state
   logic [rcbp_pkg::WORD_BITS-1:0] word_acc;
   int unsigned                    free_bits;

   rcbp_pkg::rsp_type pending_words[$];
   int unsigned       error_count = 0;
   int unsigned       words_checked = 0;
   int unsigned       flush_count = 0;
   int unsigned       reject_count = 0;
   logic              calm = 1'b0;

   code_row_type directed_rows [DIRECTED_COUNT] = '{
      '{'{rcbp_pkg::OP_FLUSH,  4'd0,  27'd0},       1'b1, '{64'd0, 1'b0, 1'b1}},
      '{'{rcbp_pkg::OP_ENCODE, 4'd0,  27'd63},      1'b1, '{64'd1, 1'b0, 1'b1}},
      '{'{rcbp_pkg::OP_ENCODE, 4'd0,  27'd64},      1'b1, '{64'd0, 1'b0, 1'b1}},
      '{'{rcbp_pkg::OP_FLUSH,  4'd15, 27'h7FFFFFF}, 1'b1,
        '{64'h8000_0000_0000_0000, 1'b0, 1'b1}},
      '{'{rcbp_pkg::OP_ENCODE, 4'd0,  27'h7FFFFFF}, 1'b1, REJECT_BEAT},
      '{'{rcbp_pkg::OP_ENCODE, 4'd15, 27'h7FFFFFF}, 1'b1, REJECT_BEAT},
      '{'{rcbp_pkg::OP_ENCODE, 4'd15, 27'h79E8000}, 1'b1, REJECT_BEAT},
      '{'{rcbp_pkg::OP_ENCODE, 4'd15, 27'h79E7FFF}, 1'b0, NO_BEAT},
      '{'{rcbp_pkg::OP_ENCODE, 4'd0,  27'd3900},    1'b0, NO_BEAT},
      '{'{rcbp_pkg::OP_ENCODE, 4'd0,  27'd3901},    1'b1, REJECT_BEAT},
      '{'{rcbp_pkg::OP_ENCODE, 4'd15, 27'h4000000}, 1'b0, NO_BEAT},
      '{'{rcbp_pkg::OP_ENCODE, 4'd14, 27'h0003FFF}, 1'b0, NO_BEAT},
      '{'{rcbp_pkg::OP_ENCODE, 4'd1,  27'd1},       1'b0, NO_BEAT},
      '{'{rcbp_pkg::OP_ENCODE, 4'd8,  27'h00000A5}, 1'b0, NO_BEAT},
      '{'{rcbp_pkg::OP_ENCODE, 4'd3,  27'd5},       1'b0, NO_BEAT},
      '{'{rcbp_pkg::OP_ENCODE, 4'd0,  27'd0},       1'b0, NO_BEAT},
      '{'{rcbp_pkg::OP_ENCODE, 4'd15, 27'h2AAAAAA}, 1'b0, NO_BEAT},
      '{'{rcbp_pkg::OP_ENCODE, 4'd7,  27'h0005555}, 1'b0, NO_BEAT},
      '{'{rcbp_pkg::OP_FLUSH,  4'd9,  27'h1234567}, 1'b0, NO_BEAT},
      '{'{rcbp_pkg::OP_FLUSH,  4'd0,  27'd0},       1'b0, NO_BEAT}
   };

   rice_code_bit_packer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Works out the words one item gives and advances the packing state.
   task automatic pack_code(input rcbp_pkg::req_type item, output rcbp_pkg::rsp_type words[$]);
      int unsigned                    k;
      int unsigned                    zeros;
      int unsigned                    len;
      logic [rcbp_pkg::WORD_BITS-1:0] tail;
      rcbp_pkg::rsp_type              beat;
      words = {};
      if (item.operation == rcbp_pkg::OP_FLUSH) begin
         words.push_back('{packed_word: word_acc, rejected: 1'b0, last_word: 1'b1});
         return;
      end
      k = (item.low_bit_count > rcbp_pkg::MAX_K) ? rcbp_pkg::MAX_K : item.low_bit_count;
      zeros = item.code_value >> k;
      if (zeros > rcbp_pkg::MAX_QUOTIENT) begin
         words.push_back(REJECT_BEAT);
         return;
      end
      if (zeros >= free_bits) begin
         zeros -= free_bits;
         words.push_back('{packed_word: word_acc, rejected: 1'b0, last_word: 1'b0});
         word_acc = '0;
         while (zeros >= rcbp_pkg::WORD_BITS) begin
            zeros -= rcbp_pkg::WORD_BITS;
            words.push_back(NO_BEAT);
         end
         free_bits = rcbp_pkg::WORD_BITS;
      end
      free_bits -= zeros;
      tail = (64'(item.code_value) & ((64'd1 << k) - 64'd1)) | (64'd1 << k);
      len = k + 1;
      // stop bit and low bits may straddle the word boundary
      if (len >= free_bits) begin
         len -= free_bits;
         word_acc |= tail >> len;
         tail &= (64'd1 << len) - 64'd1;
         words.push_back('{packed_word: word_acc, rejected: 1'b0, last_word: 1'b0});
         word_acc = '0;
         free_bits = rcbp_pkg::WORD_BITS;
      end
      if (len != 0) begin
         free_bits -= len;
         word_acc |= tail << free_bits;
      end
      if (words.size() != 0) begin
         beat = words.pop_back();
         beat.last_word = 1'b1;
         words.push_back(beat);
      end
   endtask

   function automatic int unsigned idle_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   task automatic send_item(input rcbp_pkg::req_type item, input logic typed,
                            input rcbp_pkg::rsp_type golden);
      rcbp_pkg::rsp_type words[$];
      int unsigned       gap;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      pack_code(item, words);
      if (typed)
         words = {golden};
      if (item.operation == rcbp_pkg::OP_FLUSH)
         flush_count++;
      else if (words.size() != 0 && words[0].rejected)
         reject_count++;
      foreach (words[i])
         pending_words.push_back(words[i]);
      gap = idle_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // receiver: ready stretches broken by stalls
   initial begin
      int unsigned stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         stall = idle_gap();
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      rcbp_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            $error("unexpected result beat: packed_word %h", rsp_data.packed_word);
            error_count++;
         end else begin
            want = pending_words.pop_front();
            words_checked++;
            if (rsp_data.packed_word !== want.packed_word) begin
               $error("packed_word: expected %h, got %h", want.packed_word, rsp_data.packed_word);
               error_count++;
            end
            if (rsp_data.rejected !== want.rejected) begin
               $error("rejected: expected %b, got %b", want.rejected, rsp_data.rejected);
               error_count++;
            end
            if (rsp_data.last_word !== want.last_word) begin
               $error("last_word: expected %b, got %b", want.last_word, rsp_data.last_word);
               error_count++;
            end
         end
      end
   end

   initial begin
      rcbp_pkg::req_type item;
      int unsigned       k;
      int unsigned       roll;
      int unsigned       quot;
      int unsigned       value;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      word_acc   = '0;
      free_bits  = rcbp_pkg::WORD_BITS;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].golden);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n % 160) >= 120;
         if (n == RANDOM_ITEMS / 2) begin
            // hold off until the packer has handed out everything owed
            req_valid <= 1'b0;
            do @(posedge clock); while (pending_words.size() != 0);
         end
         k    = $urandom_range(0, rcbp_pkg::MAX_K);
         roll = $urandom_range(0, 99);
         if (roll < 6) begin
            item.operation     = rcbp_pkg::OP_FLUSH;
            item.low_bit_count = rcbp_pkg::K_BITS'(k);
            item.code_value    = rcbp_pkg::VALUE_BITS'($urandom);
         end else begin
            if (roll < 72)
               quot = $urandom_range(0, 6);
            else if (roll < 88)
               quot = $urandom_range(7, 120);
            else if (roll < 94)
               quot = $urandom_range(121, rcbp_pkg::MAX_QUOTIENT);
            else
               quot = $urandom_range(rcbp_pkg::MAX_QUOTIENT + 1,
                                     ((1 << rcbp_pkg::VALUE_BITS) - 1) >> k);
            value = (quot << k) | ($urandom & ((1 << k) - 1));
            item.operation     = rcbp_pkg::OP_ENCODE;
            item.low_bit_count = rcbp_pkg::K_BITS'(k);
            item.code_value    = rcbp_pkg::VALUE_BITS'(value);
         end
         send_item(item, 1'b0, NO_BEAT);
      end
      req_valid <= 1'b0;

      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d table rows and %0d random items (%0d flushes, %0d rejects).",
               DIRECTED_COUNT, RANDOM_ITEMS, flush_count, reject_count);
      $display("%0d result beats compared, %0d mismatches.", words_checked, error_count);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
